// ----- src/otst_pkg.sv -----
// ----------------------------------------------------------------------------
// otst_pkg
// Shared widths, request and result codes for the one-shot timer slot table.
// ----------------------------------------------------------------------------
package otst_pkg;

	// number of timer slots (1 to 16)
	localparam int NUM_SLOTS = 10;
	localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// field widths
	localparam int REQ_W   = 2;
	localparam int ID_W    = 16;
	localparam int ARG_W   = 32;
	localparam int TICK_W  = 32;
	localparam int SLOT_W  = 4;
	localparam int KIND_W  = 3;
	localparam int ENTRY_W = TICK_W + ID_W + ARG_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CREATED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;

	// one slot as held in the table memory
	typedef struct packed {
		logic [TICK_W-1:0] deadline;
		logic [ID_W-1:0]   callback;
		logic [ARG_W-1:0]  argument;
	} entry_t;

endpackage

// ----- src/otst_req_if.sv -----
// ----------------------------------------------------------------------------
// otst_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface otst_req_if;
	logic                          valid;
	logic                          ready;
	logic [otst_pkg::REQ_W-1:0]    req_type;
	logic [otst_pkg::ID_W-1:0]     callback_id;
	logic [otst_pkg::ARG_W-1:0]    callback_arg;
	logic [otst_pkg::TICK_W-1:0]   timeout;
	logic [otst_pkg::SLOT_W-1:0]   slot;

	modport source (
		output valid, req_type, callback_id, callback_arg, timeout, slot,
		input  ready
	);
	modport sink (
		input  valid, req_type, callback_id, callback_arg, timeout, slot,
		output ready
	);
endinterface

// ----- src/otst_rsp_if.sv -----
// ----------------------------------------------------------------------------
// otst_rsp_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface otst_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [otst_pkg::KIND_W-1:0]   result_kind;
	logic [otst_pkg::SLOT_W-1:0]   slot_out;
	logic [otst_pkg::ID_W-1:0]     callback_id_out;
	logic [otst_pkg::ARG_W-1:0]    callback_arg_out;
	logic [otst_pkg::TICK_W-1:0]   tick_now;
	logic                          last;

	modport source (
		output valid, result_kind, slot_out, callback_id_out, callback_arg_out,
		       tick_now, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, slot_out, callback_id_out, callback_arg_out,
		       tick_now, last,
		output ready
	);
endinterface

// ----- src/otst_ram.sv -----
// ----------------------------------------------------------------------------
// otst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module otst_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/oneshot_timer_slot_table.sv -----
// ----------------------------------------------------------------------------
// oneshot_timer_slot_table
// Table of one-shot timer slots with a free-running tick count.
// ----------------------------------------------------------------------------
// Usage:
//   req : request words (create, delete, tick). One request is worked on at
//         a time; ready is high while the sequencer is idle.
//   rsp : result words from a single output register. Create and delete give
//         one word; a tick gives one expiry word per expiring slot, in slot
//         order, then a tick-done word. The final word of a request has last.
// Sequence:
//   create / delete : accepted while idle; the result is registered in the
//                     create or delete state once the output register is free.
//   tick            : each busy slot is read from the slot memory (one read
//                     port, registered read) and its deadline compared; free
//                     slots are skipped, then the tick-done word follows.
//   A request code with no meaning is taken and dropped with no result.
// A stalled receiver holds the result word; the sequencer waits on the next
// word, and a new request is still taken while the last word waits.
// Reset clears the tick count and all busy flags; the slot memory needs no
// clearing as an entry is only read once a create has written it.
// ----------------------------------------------------------------------------
module oneshot_timer_slot_table (
	input  logic             clk,
	input  logic             arst_n,
	otst_req_if.sink         req,
	otst_rsp_if.source       rsp
);

	localparam int AW = otst_pkg::SLOT_AW;
	localparam logic [AW-1:0] LAST_IDX = AW'(otst_pkg::NUM_SLOTS - 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CREATE = 3'd1;
	localparam logic [2:0] ST_DELETE = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]                        state_q;
	logic [otst_pkg::TICK_W-1:0]       tick_q;
	logic [otst_pkg::NUM_SLOTS-1:0]    busy_q;
	logic [AW-1:0]                     idx_q;

	// latched request
	logic [otst_pkg::ID_W-1:0]         id_q;
	logic [otst_pkg::ARG_W-1:0]        arg_q;
	logic [otst_pkg::TICK_W-1:0]       tmo_q;
	logic [otst_pkg::SLOT_W-1:0]       slot_q;

	// output register
	logic                              out_valid_q;
	logic [otst_pkg::KIND_W-1:0]       kind_q;
	logic [otst_pkg::SLOT_W-1:0]       slot_out_q;
	logic [otst_pkg::ID_W-1:0]         id_out_q;
	logic [otst_pkg::ARG_W-1:0]        arg_out_q;
	logic [otst_pkg::TICK_W-1:0]       tick_out_q;
	logic                              last_q;

	logic                              out_free;
	logic                              load_word;
	logic                              free_found;
	logic [AW-1:0]                     free_idx;
	logic                              create_ok;
	logic                              del_in_range;
	logic                              ram_we;
	logic                              ram_re;
	otst_pkg::entry_t                  wr_entry;
	otst_pkg::entry_t                  rd_entry;
	logic                              expire;

	assign out_free = !out_valid_q || rsp.ready;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = otst_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	assign create_ok    = (id_q != '0) && (tmo_q != '0) && free_found;
	assign del_in_range = {1'b0, slot_q} < (otst_pkg::SLOT_W + 1)'(otst_pkg::NUM_SLOTS);

	// table memory access
	assign wr_entry.deadline = tick_q + tmo_q;
	assign wr_entry.callback = id_q;
	assign wr_entry.argument = arg_q;
	assign ram_we = (state_q == ST_CREATE) && out_free && create_ok;
	assign ram_re = (state_q == ST_READ) && busy_q[idx_q];
	assign expire = busy_q[idx_q] && (rd_entry.deadline <= tick_q);

	otst_ram #(
		.WIDTH (otst_pkg::ENTRY_W),
		.DEPTH (otst_pkg::NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	assign req.ready = (state_q == ST_IDLE);

	// a new result word enters the output register
	assign load_word = out_free && ((state_q == ST_CREATE) || (state_q == ST_DELETE) ||
		((state_q == ST_CHECK) && expire) || (state_q == ST_DONE));

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_word) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer, slot flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			busy_q      <= '0;
			idx_q       <= '0;
			id_q        <= '0;
			arg_q       <= '0;
			tmo_q       <= '0;
			slot_q      <= '0;
			kind_q      <= otst_pkg::KIND_CREATED;
			slot_out_q  <= '0;
			id_out_q    <= '0;
			arg_out_q   <= '0;
			tick_out_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						id_q   <= req.callback_id;
						arg_q  <= req.callback_arg;
						tmo_q  <= req.timeout;
						slot_q <= req.slot;
						idx_q  <= '0;
						unique case (req.req_type)
							otst_pkg::REQ_CREATE: state_q <= ST_CREATE;
							otst_pkg::REQ_DELETE: state_q <= ST_DELETE;
							otst_pkg::REQ_TICK: begin
								tick_q  <= tick_q + 1'b1;
								state_q <= ST_READ;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CREATE: begin
					if (out_free) begin
						id_out_q    <= '0;
						arg_out_q   <= '0;
						tick_out_q  <= tick_q;
						last_q      <= 1'b1;
						if (create_ok) begin
							busy_q[free_idx] <= 1'b1;
							kind_q           <= otst_pkg::KIND_CREATED;
							slot_out_q       <= otst_pkg::SLOT_W'(free_idx);
						end else begin
							kind_q     <= otst_pkg::KIND_REJECTED;
							slot_out_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DELETE: begin
					if (out_free) begin
						if (del_in_range) begin
							busy_q[slot_q[AW-1:0]] <= 1'b0;
						end
						kind_q      <= otst_pkg::KIND_DELETED;
						slot_out_q  <= '0;
						id_out_q    <= '0;
						arg_out_q   <= '0;
						tick_out_q  <= tick_q;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_READ: begin
					// free slots are skipped without a memory read
					if (busy_q[idx_q]) begin
						state_q <= ST_CHECK;
					end else if (idx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (!expire || out_free) begin
						if (expire) begin
							busy_q[idx_q] <= 1'b0;
							kind_q        <= otst_pkg::KIND_EXPIRED;
							slot_out_q    <= otst_pkg::SLOT_W'(idx_q);
							id_out_q      <= rd_entry.callback;
							arg_out_q     <= rd_entry.argument;
							tick_out_q    <= tick_q;
							last_q        <= 1'b0;
						end
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						kind_q      <= otst_pkg::KIND_TICK_DONE;
						slot_out_q  <= '0;
						id_out_q    <= '0;
						arg_out_q   <= '0;
						tick_out_q  <= tick_q;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.result_kind      = kind_q;
	assign rsp.slot_out         = slot_out_q;
	assign rsp.callback_id_out  = id_out_q;
	assign rsp.callback_arg_out = arg_out_q;
	assign rsp.tick_now         = tick_out_q;
	assign rsp.last             = last_q;

endmodule
